@@ hdl/dlbd_pkg.sv @@
package dlbd_pkg;

	// byte codes of the block framing
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LF   = 8'h0A;

	typedef enum logic [2:0] {
		KIND_SAMPLE    = 3'd0,
		KIND_DONE      = 3'd1,
		KIND_BAD_START = 3'd2,
		KIND_BAD_COUNT = 3'd3,
		KIND_BAD_DIGIT = 3'd4,
		KIND_BAD_END   = 3'd5
	} kind_t;

	typedef struct packed {
		logic signed [15:0] sample;
		kind_t              kind;
		logic               last;
	} result_t;

endpackage

@@ hdl/dlbd_if.sv @@
interface dlbd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface dlbd_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic [2:0]         kind;
	logic               last;

	modport source (output valid, output sample, output kind, output last, input ready);
	modport sink (input valid, input sample, input kind, input last, output ready);
endinterface

@@ hdl/dlbd_parse.sv @@
module dlbd_parse
	import dlbd_pkg::*;
#(
	parameter int MAX_LEN_DIGITS = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output logic       push,
	output result_t    push_data
);

	localparam int DW    = $clog2(MAX_LEN_DIGITS + 1);
	localparam int LEN_W = $clog2(10 ** MAX_LEN_DIGITS);

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_COUNT   = 3'd1,
		PH_LEN     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_END     = 3'd4
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [DW-1:0]      digits_left_q, digits_left_d;
	logic [LEN_W-1:0]   bytes_left_q, bytes_left_d;
	logic [7:0]         low_byte_q, low_byte_d;
	logic               odd_q, odd_d;

	logic               is_digit;
	logic [7:0]         digit8;
	logic [3:0]         digit;
	logic [LEN_W-1:0]   times10;

	assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign digit8   = rx_byte - CH_ZERO;
	assign digit    = digit8[3:0];
	// bytes_left * 10 + digit, as two shifted adds
	assign times10  = (bytes_left_q << 3) + (bytes_left_q << 1) + LEN_W'(digit);

	always_comb begin
		phase_d          = phase_q;
		digits_left_d    = digits_left_q;
		bytes_left_d     = bytes_left_q;
		low_byte_d       = low_byte_q;
		odd_d            = odd_q;
		push             = 1'b0;
		push_data.sample = '0;
		push_data.kind   = KIND_SAMPLE;
		push_data.last   = 1'b1;
		case (phase_q)
			PH_COUNT: begin
				if (!is_digit || (32'(digit) > 32'(MAX_LEN_DIGITS))) begin
					phase_d        = PH_WAIT;
					push           = 1'b1;
					push_data.kind = KIND_BAD_COUNT;
				end else begin
					digits_left_d = DW'(digit);
					bytes_left_d  = '0;
					phase_d       = (digit == 4'd0) ? PH_END : PH_LEN;
				end
			end
			PH_LEN: begin
				if (!is_digit) begin
					phase_d        = PH_WAIT;
					push           = 1'b1;
					push_data.kind = KIND_BAD_DIGIT;
				end else begin
					bytes_left_d  = times10;
					digits_left_d = digits_left_q - DW'(1);
					if (digits_left_q == DW'(1)) begin
						phase_d = (times10 == '0) ? PH_END : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (!odd_q) begin
					low_byte_d = rx_byte;
					odd_d      = 1'b1;
				end else begin
					push             = 1'b1;
					push_data.sample = {rx_byte, low_byte_q};
					push_data.kind   = KIND_SAMPLE;
					push_data.last   = 1'b0;
					odd_d            = 1'b0;
				end
				bytes_left_d = bytes_left_q - LEN_W'(1);
				// a trailing odd byte is dropped here
				if (bytes_left_q == LEN_W'(1)) begin
					phase_d = PH_END;
					odd_d   = 1'b0;
				end
			end
			PH_END: begin
				phase_d        = PH_WAIT;
				push           = 1'b1;
				push_data.kind = (rx_byte == CH_LF) ? KIND_DONE : KIND_BAD_END;
			end
			default: begin
				if (rx_byte == CH_HASH) begin
					phase_d = PH_COUNT;
				end else begin
					phase_d        = PH_WAIT;
					push           = 1'b1;
					push_data.kind = KIND_BAD_START;
				end
			end
		endcase
		if (!take) begin
			push = 1'b0;
		end
		if (phase_d == PH_WAIT) begin
			digits_left_d = '0;
			bytes_left_d  = '0;
			odd_d         = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			digits_left_q <= '0;
			bytes_left_q  <= '0;
			odd_q         <= 1'b0;
		end else if (take) begin
			phase_q       <= phase_d;
			digits_left_q <= digits_left_d;
			bytes_left_q  <= bytes_left_d;
			odd_q         <= odd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			low_byte_q <= low_byte_d;
		end
	end

`ifndef SYNTHESIS
	a_odd_only_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		odd_q |-> (phase_q == PH_PAYLOAD))
		else $error("half sample held outside payload");
	a_len_has_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEN) |-> (digits_left_q != '0))
		else $error("length phase with no digits left");
	a_payload_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (bytes_left_q != '0))
		else $error("payload phase with no bytes left");
	a_last_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.last == (push_data.kind != KIND_SAMPLE)))
		else $error("last flag disagrees with kind");
`endif

endmodule

@@ hdl/dlbd_outreg.sv @@
module dlbd_outreg
	import dlbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_vld_q;
	logic    skid_vld_q;
	result_t main_q;
	result_t skid_q;

	assign in_ready  = !skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || out_ready) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || out_ready) begin
			main_q <= skid_vld_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry without an output entry");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_vld_q)
		else $error("result pushed into a full skid stage");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && out_ready) |=> (main_vld_q && !skid_vld_q))
		else $error("skid entry not moved after output transfer");
`endif

endmodule

@@ hdl/definite_length_block_deframer.sv @@
// definite-length block deframer
//
// rx carries one received byte per transfer; res carries one result per
// transfer: a signed 16-bit sample (kind sample, last low), or a block
// closing code (done, bad start, bad count digit, bad length digit, bad
// ending) with last high and sample zero.
// a block is '#', one count digit, that many length digits, the payload and
// a newline; payload bytes pair into samples, first byte low, and a trailing
// odd byte is dropped. after any error the parser waits for a new '#'.
//
// throughput: one byte per cycle while the skid entry is free. the parser
// state updates in the cycle a byte transfers and its result is registered
// into the output register, or into the skid entry when res stalls.
// when res stalls, a one-entry skid stage takes the next result and rx
// keeps moving; rx.ready drops only while that skid entry is occupied.
// reset clears the parser to waiting for '#' and empties both output
// entries; nothing is pending after reset.
module definite_length_block_deframer
	import dlbd_pkg::*;
#(
	parameter int MAX_LEN_DIGITS = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	dlbd_byte_if.sink      rx,
	dlbd_result_if.source  res
);

	logic    take;
	logic    push;
	result_t push_data;
	logic    in_ready;
	result_t out_data;

	// a byte moves whenever the skid stage has room
	assign rx.ready = in_ready;
	assign take     = rx.valid && in_ready;

	// byte parser and sample assembly
	dlbd_parse #(
		.MAX_LEN_DIGITS (MAX_LEN_DIGITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx.rx_byte),
		.push      (push),
		.push_data (push_data)
	);

	// result register with skid entry
	dlbd_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.in_ready  (in_ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (out_data)
	);

	assign res.sample = out_data.sample;
	assign res.kind   = out_data.kind;
	assign res.last   = out_data.last;

endmodule

@@ tb/definite_length_block_deframer_tb.sv @@
module definite_length_block_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dlbd_pkg::*;

	localparam int MAX_LEN = 9;
	// cycles with no transfer on either side before the run is declared hung;
	// well above the long receiver hold plus the longest random gaps
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 300;
	localparam int ITEM_TARGET = 700;

	// parser phases as the predictor tracks them
	typedef enum logic [2:0] {
		PARSE_WAIT    = 3'd0,
		PARSE_COUNT   = 3'd1,
		PARSE_LEN     = 3'd2,
		PARSE_PAYLOAD = 3'd3,
		PARSE_END     = 3'd4
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n;

	dlbd_byte_if   rx_if ();
	dlbd_result_if res_if ();

	definite_length_block_deframer #(
		.MAX_LEN_DIGITS(MAX_LEN)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if)
	);

	always #1 clk = ~clk;

	// bytes still to be offered, and results the parser is owed
	logic [7:0] rx_stream[$];
	result_t    pending_results[$];
	int         bytes_queued;
	int         mismatches;

	// knobs the stimulus phases flip, changed only on the falling edge
	bit sender_idle;
	bit receiver_idle;
	bit want_long_hold;

	// predictor copy of the parser state
	parse_phase_t pred_phase;
	logic [3:0]   pred_digits;
	logic [29:0]  pred_remaining;
	logic [7:0]   pred_low;
	logic         pred_low_valid;

	function automatic void parser_to_wait();
		pred_phase     = PARSE_WAIT;
		pred_digits    = '0;
		pred_remaining = '0;
		pred_low       = '0;
		pred_low_valid = 1'b0;
	endfunction

	// advance the predicted parser by one byte; returns 1 when a result is owed
	function automatic bit parse_byte(input logic [7:0] b, output result_t r);
		logic [7:0] d;
		bit         is_digit;
		bit         owed;
		d        = b - CH_ZERO;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		owed     = 1'b0;
		r        = '0;
		case (pred_phase)
			PARSE_COUNT: begin
				if (!is_digit || d > MAX_LEN) begin
					parser_to_wait();
					r.kind = KIND_BAD_COUNT;
					r.last = 1'b1;
					owed   = 1'b1;
				end else begin
					pred_digits    = d[3:0];
					pred_remaining = '0;
					// count digit zero means an empty block, ending comes next
					pred_phase     = (d == 8'd0) ? PARSE_END : PARSE_LEN;
				end
			end
			PARSE_LEN: begin
				if (!is_digit) begin
					parser_to_wait();
					r.kind = KIND_BAD_DIGIT;
					r.last = 1'b1;
					owed   = 1'b1;
				end else begin
					pred_remaining = pred_remaining * 30'd10 + 30'(d);
					pred_digits    = pred_digits - 4'd1;
					// an all-zero length also goes straight to the ending
					if (pred_digits == 4'd0)
						pred_phase = (pred_remaining == '0) ? PARSE_END : PARSE_PAYLOAD;
				end
			end
			PARSE_PAYLOAD: begin
				if (!pred_low_valid) begin
					pred_low       = b;
					pred_low_valid = 1'b1;
				end else begin
					r.sample       = {b, pred_low};
					r.kind         = KIND_SAMPLE;
					r.last         = 1'b0;
					owed           = 1'b1;
					pred_low_valid = 1'b0;
					pred_low       = '0;
				end
				pred_remaining = pred_remaining - 30'd1;
				// odd trailing byte is dropped here without a result
				if (pred_remaining == '0) begin
					pred_phase     = PARSE_END;
					pred_low_valid = 1'b0;
					pred_low       = '0;
				end
			end
			PARSE_END: begin
				parser_to_wait();
				r.kind = (b == CH_LF) ? KIND_DONE : KIND_BAD_END;
				r.last = 1'b1;
				owed   = 1'b1;
			end
			default: begin
				parser_to_wait();
				if (b == CH_HASH) begin
					pred_phase = PARSE_COUNT;
				end else begin
					r.kind = KIND_BAD_START;
					r.last = 1'b1;
					owed   = 1'b1;
				end
			end
		endcase
		return owed;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	// ---------------------------------------------------------------
	// byte driver: offers the next queued byte, holds it until transfer
	// ---------------------------------------------------------------
	int      tx_gap;
	result_t predicted;

	always @(posedge clk) begin
		if (!arst_n) begin
			rx_if.valid   <= 1'b0;
			rx_if.rx_byte <= '0;
			tx_gap = 0;
		end else begin
			// byte transfer: predict what the parser owes for it
			if (rx_if.valid && rx_if.ready) begin
				if (parse_byte(rx_if.rx_byte, predicted))
					pending_results.push_back(predicted);
			end
			if (!rx_if.valid || rx_if.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					rx_if.valid <= 1'b0;
				end else if (rx_stream.size() > 0) begin
					rx_if.valid   <= 1'b1;
					rx_if.rx_byte <= rx_stream.pop_front();
					if (sender_idle && $urandom_range(0, 2) == 0)
						tx_gap = pick_gap();
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor: random back-pressure plus one long hold-off
	// ---------------------------------------------------------------
	int      rx_stall;
	int      hold_left;
	bit      hold_taken;
	result_t oldest;

	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			rx_stall   = 0;
			hold_left  = 0;
			hold_taken = 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result sample=%0d kind=%0d last=%0d",
						$time, res_if.sample, res_if.kind, res_if.last);
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					if (res_if.sample !== oldest.sample) begin
						$display("%0t: sample expected %0d actual %0d",
							$time, oldest.sample, res_if.sample);
						mismatches++;
					end
					if (res_if.kind !== oldest.kind) begin
						$display("%0t: kind expected %0d actual %0d",
							$time, oldest.kind, res_if.kind);
						mismatches++;
					end
					if (res_if.last !== oldest.last) begin
						$display("%0t: last expected %0d actual %0d",
							$time, oldest.last, res_if.last);
						mismatches++;
					end
				end
			end
			// long hold-off so the skid entry fills and rx has to stall
			if (want_long_hold && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
				if (receiver_idle && $urandom_range(0, 3) == 0)
					rx_stall = pick_gap();
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog: cycles in which no transfer happens on either side
	// ---------------------------------------------------------------
	int quiet_cycles;

	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		rx_stream.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// full block: header, random payload, newline or a wrong closing byte
	task automatic push_block(input int digits, input int len, input bit good_end);
		int         p;
		logic [7:0] b;
		push_byte(CH_HASH);
		push_byte(CH_ZERO + 8'(digits));
		for (int i = digits - 1; i >= 0; i--) begin
			p = 1;
			repeat (i) p *= 10;
			push_byte(CH_ZERO + 8'((len / p) % 10));
		end
		repeat (len) push_byte(8'($urandom_range(0, 255)));
		if (good_end) begin
			push_byte(CH_LF);
		end else begin
			do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
			push_byte(b);
		end
	endtask

	// one random chunk: mostly well-formed blocks, some broken headers and noise
	task automatic push_random_chunk();
		int r;
		int digits;
		int len;
		int cap;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				digits = 0;
			else if (r < 85)
				digits = $urandom_range(1, 3);
			else
				digits = $urandom_range(4, MAX_LEN);
			cap = (digits == 1) ? 9 : 40;
			if (digits == 0)
				len = 0;
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(0, cap);
			else
				len = $urandom_range(0, (cap < 12) ? cap : 12);
			push_block(digits, len, $urandom_range(0, 9) != 0);
		end else if (r < 85) begin
			// '#' followed by anything: mostly a bad count digit
			push_byte(CH_HASH);
			push_byte(8'($urandom_range(0, 255)));
		end else if (r < 92) begin
			// length field cut short by a non-digit
			push_byte(CH_HASH);
			push_byte(CH_ZERO + 8'($urandom_range(2, 4)));
			push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
			push_byte(8'($urandom_range(CH_NINE + 1, 255)));
		end else begin
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic drain_stream();
		while (rx_stream.size() != 0) @(negedge clk);
	endtask

	initial begin
		arst_n         = 1'b0;
		rx_if.valid    = 1'b0;
		rx_if.rx_byte  = '0;
		res_if.ready   = 1'b0;
		sender_idle    = 1'b0;
		receiver_idle  = 1'b0;
		want_long_hold = 1'b0;
		bytes_queued   = 0;
		mismatches     = 0;
		quiet_cycles   = 0;
		parser_to_wait();

		// directed: stray byte, empty block, bad count digit, zero length,
		// bad length digit, full-scale positive sample with bad ending, odd payload
		push_byte(8'h00);
		push_text("#0\n");
		push_text("#:");
		push_text("#10\n");
		push_text("#2x");
		push_text("#12");
		push_byte(8'hFF);
		push_byte(8'h7F);
		push_byte("Z");
		push_text("#3003");
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(CH_LF);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drain_stream();

		// random traffic with idling on both sides
		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		while (bytes_queued < 300) push_random_chunk();
		drain_stream();

		// sender runs flat out while the receiver holds off for a long stretch
		sender_idle    = 1'b0;
		receiver_idle  = 1'b0;
		want_long_hold = 1'b1;
		while (bytes_queued < 450) push_random_chunk();
		drain_stream();

		// back to back on both sides
		while (bytes_queued < 550) push_random_chunk();
		drain_stream();

		sender_idle   = 1'b1;
		receiver_idle = 1'b1;
		while (bytes_queued < ITEM_TARGET) push_random_chunk();
		drain_stream();

		// last byte transferred, then every owed result arrived, then a short tail
		while (rx_if.valid) @(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
